// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TFN_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is low
`define TFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/tfn_pkg.sv =====
// widths, constants and types of the face normal unit
package tfn_pkg;

    // coordinate and cross product widths
    localparam int CW    = 16;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int NW    = PW + 1;
    localparam int MW    = PW;
    localparam int HW    = $clog2(MW);
    localparam int THW   = 32;
    localparam int SQW   = 2 * DW;

    // reduced magnitudes and their squares
    localparam int AW    = 20;
    localparam int ASQW  = 2 * AW;
    localparam int LW    = ASQW + 2;

    // output format
    localparam int F     = 14;
    localparam int OW    = 16;
    localparam int QDW   = 2 * F + 3;
    localparam int RW    = F + 2;
    localparam int SW    = QDW + 2;

    // latencies
    localparam int FRONT_LAT = 7;
    localparam int LANE_LAT  = QDW + RW + 1;

    localparam logic [THW-1:0] THR_RESET = THW'(1);
    localparam logic signed [OW-1:0] DEGEN_X = OW'(1 << F);

    // front end to the component lanes
    typedef struct packed {
        logic                     vld;
        logic                     degen;
        logic [2:0]               neg;
        logic [LW-1:0]            len;
        logic [2:0][ASQW-1:0]     asq;
    } t_front;

    // one result item
    typedef struct packed {
        logic signed [OW-1:0] x;
        logic signed [OW-1:0] y;
        logic signed [OW-1:0] z;
        logic                 degen;
    } t_result;

endpackage

// ===== rtl/triangle_unit_face_normal.sv =====
// top level of the triangle unit face normal pipeline
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+----------------------------------------
//  in      | i_valid | o_stall | i_p0_x .. i_p2_z
//  out     | o_valid | i_stall | o_normal_x/y/z, o_degenerate
//  cfg     | i_cfg_we| -       | i_cfg_data (degenerate threshold)
//
// one triangle per cycle while o_stall is low; from transfer in to o_valid a triangle passes
// 7 front end stages, 31 divide stages, 16 root stages, rounding and the output register
// the divide and square root run one bit per stage in each component lane
// reset clears valid bits and loads the threshold with 1
// a stalled output parks one result in a skid register; o_stall is that
// register's full flag, so the input stalls only once that register has filled
`include "assert_macros.svh"

module triangle_unit_face_normal (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [tfn_pkg::CW-1:0]     i_p0_x,
    input  logic signed [tfn_pkg::CW-1:0]     i_p0_y,
    input  logic signed [tfn_pkg::CW-1:0]     i_p0_z,
    input  logic signed [tfn_pkg::CW-1:0]     i_p1_x,
    input  logic signed [tfn_pkg::CW-1:0]     i_p1_y,
    input  logic signed [tfn_pkg::CW-1:0]     i_p1_z,
    input  logic signed [tfn_pkg::CW-1:0]     i_p2_x,
    input  logic signed [tfn_pkg::CW-1:0]     i_p2_y,
    input  logic signed [tfn_pkg::CW-1:0]     i_p2_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [tfn_pkg::OW-1:0]     o_normal_x,
    output logic signed [tfn_pkg::OW-1:0]     o_normal_y,
    output logic signed [tfn_pkg::OW-1:0]     o_normal_z,
    output logic                              o_degenerate,
    input  logic                              i_cfg_we,
    input  logic [tfn_pkg::THW-1:0]           i_cfg_data
);

    localparam int LAT = tfn_pkg::LANE_LAT;

    logic [tfn_pkg::THW-1:0]        r_thr;
    logic                           r_ov, r_sv;
    tfn_pkg::t_result               r_o, r_s, w_pd;
    logic [LAT-1:0]                 r_lvld, r_ldgn;
    logic                           w_en, w_pv;
    tfn_pkg::t_front                w_front;
    logic signed [tfn_pkg::OW-1:0]  w_q [3];

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= tfn_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // whole pipeline advances unless the skid register is holding
    assign w_en    = !r_sv;
    assign o_stall = r_sv;

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_p0_x  (i_p0_x),
        .i_p0_y  (i_p0_y),
        .i_p0_z  (i_p0_z),
        .i_p1_x  (i_p1_x),
        .i_p1_y  (i_p1_y),
        .i_p1_z  (i_p1_z),
        .i_p2_x  (i_p2_x),
        .i_p2_y  (i_p2_y),
        .i_p2_z  (i_p2_z),
        .i_thr   (r_thr),
        .o_front (w_front)
    );

    for (genvar c = 0; c < 3; c++) begin : g_lane
        tfn_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_asq (w_front.asq[c]),
            .i_len (w_front.len),
            .i_neg (w_front.neg[c]),
            .o_q   (w_q[c])
        );
    end

    // valid and degenerate flag alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= '0;
        end else if (w_en) begin
            r_lvld <= {r_lvld[LAT-2:0], w_front.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ldgn <= {r_ldgn[LAT-2:0], w_front.degen};
        end
    end

    // result of the last stage
    assign w_pv       = r_lvld[LAT-1] && w_en;
    assign w_pd.degen = r_ldgn[LAT-1];
    assign w_pd.x     = r_ldgn[LAT-1] ? tfn_pkg::DEGEN_X : w_q[0];
    assign w_pd.y     = r_ldgn[LAT-1] ? '0 : w_q[1];
    assign w_pd.z     = r_ldgn[LAT-1] ? '0 : w_q[2];

    // output register with skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_pv;
            end
        end else if (w_pv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_o <= r_sv ? r_s : w_pd;
        end else if (w_pv) begin
            r_s <= w_pd;
        end
    end

    assign o_valid      = r_ov;
    assign o_normal_x   = r_o.x;
    assign o_normal_y   = r_o.y;
    assign o_normal_z   = r_o.z;
    assign o_degenerate = r_o.degen;

    // checks
    `TFN_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_sv, r_ov)
    `TFN_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_sv && i_stall, r_sv && r_ov)
    `TFN_ASSERT(a_degen_default, i_clk, i_rst_n, o_valid && o_degenerate, o_normal_x == tfn_pkg::DEGEN_X && o_normal_y == '0 && o_normal_z == '0)

endmodule

// ===== rtl/tfn_front.sv =====
// cross product, degenerate test, range reduction and squared length
module tfn_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [tfn_pkg::CW-1:0]     i_p0_x,
    input  logic signed [tfn_pkg::CW-1:0]     i_p0_y,
    input  logic signed [tfn_pkg::CW-1:0]     i_p0_z,
    input  logic signed [tfn_pkg::CW-1:0]     i_p1_x,
    input  logic signed [tfn_pkg::CW-1:0]     i_p1_y,
    input  logic signed [tfn_pkg::CW-1:0]     i_p1_z,
    input  logic signed [tfn_pkg::CW-1:0]     i_p2_x,
    input  logic signed [tfn_pkg::CW-1:0]     i_p2_y,
    input  logic signed [tfn_pkg::CW-1:0]     i_p2_z,
    input  logic [tfn_pkg::THW-1:0]           i_thr,
    output tfn_pkg::t_front                   o_front
);

    logic [tfn_pkg::FRONT_LAT-1:0]        r_vld;
    logic signed [tfn_pkg::DW-1:0]        r_u [3];
    logic signed [tfn_pkg::DW-1:0]        r_v [3];
    logic signed [tfn_pkg::PW-1:0]        r_pr [6];
    logic signed [tfn_pkg::NW-1:0]        r_n [3];
    logic [tfn_pkg::MW-1:0]               r_mag [3];
    logic [2:0]                           r_neg4, r_neg5, r_neg6, r_neg7;
    logic [tfn_pkg::AW-1:0]               r_a [3];
    logic [tfn_pkg::SQW-1:0]              r_sq [3];
    logic                                 r_big, r_zero;
    logic                                 r_degen6, r_degen7;
    logic [tfn_pkg::ASQW-1:0]             r_asq6 [3];
    logic [tfn_pkg::ASQW-1:0]             r_asq7 [3];
    logic [tfn_pkg::LW-1:0]               r_len;

    logic [tfn_pkg::MW-1:0]               w_or;
    logic [tfn_pkg::HW-1:0]               n_h;
    logic [tfn_pkg::HW-1:0]               n_s;
    logic [tfn_pkg::SQW+1:0]              w_sum;

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[tfn_pkg::FRONT_LAT-2:0], i_valid};
        end
    end

    // leading one of the largest magnitude sets the reduction shift
    assign w_or = r_mag[0] | r_mag[1] | r_mag[2];
    always_comb begin
        n_h = '0;
        for (int i = 0; i < tfn_pkg::MW; i++) begin
            if (w_or[i]) begin
                n_h = tfn_pkg::HW'(i);
            end
        end
        n_s = (n_h >= tfn_pkg::HW'(tfn_pkg::AW)) ? n_h - tfn_pkg::HW'(tfn_pkg::AW - 1) : '0;
    end

    // exact squared length for the threshold test (small normals only)
    assign w_sum = (tfn_pkg::SQW+2)'(r_sq[0]) + (tfn_pkg::SQW+2)'(r_sq[1])
                 + (tfn_pkg::SQW+2)'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // edge vectors
            r_u[0] <= tfn_pkg::DW'(i_p1_x) - tfn_pkg::DW'(i_p0_x);
            r_u[1] <= tfn_pkg::DW'(i_p1_y) - tfn_pkg::DW'(i_p0_y);
            r_u[2] <= tfn_pkg::DW'(i_p1_z) - tfn_pkg::DW'(i_p0_z);
            r_v[0] <= tfn_pkg::DW'(i_p2_x) - tfn_pkg::DW'(i_p0_x);
            r_v[1] <= tfn_pkg::DW'(i_p2_y) - tfn_pkg::DW'(i_p0_y);
            r_v[2] <= tfn_pkg::DW'(i_p2_z) - tfn_pkg::DW'(i_p0_z);
            // partial products of the cross product
            r_pr[0] <= r_u[1] * r_v[2];
            r_pr[1] <= r_u[2] * r_v[1];
            r_pr[2] <= r_u[2] * r_v[0];
            r_pr[3] <= r_u[0] * r_v[2];
            r_pr[4] <= r_u[0] * r_v[1];
            r_pr[5] <= r_u[1] * r_v[0];
            // cross product components
            r_n[0] <= tfn_pkg::NW'(r_pr[0]) - tfn_pkg::NW'(r_pr[1]);
            r_n[1] <= tfn_pkg::NW'(r_pr[2]) - tfn_pkg::NW'(r_pr[3]);
            r_n[2] <= tfn_pkg::NW'(r_pr[4]) - tfn_pkg::NW'(r_pr[5]);
            // sign and magnitude
            for (int i = 0; i < 3; i++) begin
                r_neg4[i] <= r_n[i][tfn_pkg::NW-1];
                r_mag[i]  <= r_n[i][tfn_pkg::NW-1] ? tfn_pkg::MW'(-r_n[i])
                                                   : tfn_pkg::MW'(r_n[i]);
            end
            // reduced magnitudes and small squares
            for (int i = 0; i < 3; i++) begin
                r_a[i]  <= tfn_pkg::AW'(r_mag[i] >> n_s);
                r_sq[i] <= tfn_pkg::SQW'(r_mag[i][tfn_pkg::DW-1:0])
                         * tfn_pkg::SQW'(r_mag[i][tfn_pkg::DW-1:0]);
            end
            r_big  <= |w_or[tfn_pkg::MW-1:tfn_pkg::DW];
            r_zero <= (w_or == '0);
            r_neg5 <= r_neg4;
            // threshold test and reduced squares
            r_degen6 <= r_zero | (!r_big && (w_sum < (tfn_pkg::SQW+2)'(i_thr)));
            for (int i = 0; i < 3; i++) begin
                r_asq6[i] <= tfn_pkg::ASQW'(r_a[i]) * tfn_pkg::ASQW'(r_a[i]);
            end
            r_neg6 <= r_neg5;
            // reduced squared length
            r_len <= tfn_pkg::LW'(r_asq6[0]) + tfn_pkg::LW'(r_asq6[1])
                   + tfn_pkg::LW'(r_asq6[2]);
            r_asq7   <= r_asq6;
            r_degen7 <= r_degen6;
            r_neg7   <= r_neg6;
        end
    end

    assign o_front.vld    = r_vld[tfn_pkg::FRONT_LAT-1];
    assign o_front.degen  = r_degen7;
    assign o_front.neg    = r_neg7;
    assign o_front.len    = r_len;
    assign o_front.asq[0] = r_asq7[0];
    assign o_front.asq[1] = r_asq7[1];
    assign o_front.asq[2] = r_asq7[2];

endmodule

// ===== rtl/tfn_lane.sv =====
// one normal component: pipelined divide, square root and rounding
module tfn_lane (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [tfn_pkg::ASQW-1:0]        i_asq,
    input  logic [tfn_pkg::LW-1:0]          i_len,
    input  logic                            i_neg,
    output logic signed [tfn_pkg::OW-1:0]   o_q
);

    localparam int LW  = tfn_pkg::LW;
    localparam int QDW = tfn_pkg::QDW;
    localparam int RW  = tfn_pkg::RW;
    localparam int SW  = tfn_pkg::SW;

    // divide stages: quotient of asq * 2^(2F+2) by len, one bit a stage
    logic [LW-1:0]  r_rem [QDW];
    logic [LW-1:0]  r_dlen [QDW];
    logic [QDW-1:0] r_quo [QDW];
    logic           r_dneg [QDW];

    logic [LW:0]    w_trial [QDW];
    logic [LW-1:0]  w_dlen [QDW];
    logic [QDW-1:0] w_quo [QDW];
    logic           w_dneg [QDW];

    for (genvar k = 0; k < QDW; k++) begin : g_div
        logic w_ge;
        if (k == 0) begin : g_first
            assign w_trial[k] = {1'b0, LW'(i_asq)};
            assign w_dlen[k]  = i_len;
            assign w_quo[k]   = '0;
            assign w_dneg[k]  = i_neg;
        end else begin : g_next
            assign w_trial[k] = {r_rem[k-1], 1'b0};
            assign w_dlen[k]  = r_dlen[k-1];
            assign w_quo[k]   = r_quo[k-1];
            assign w_dneg[k]  = r_dneg[k-1];
        end
        assign w_ge = (w_trial[k] >= {1'b0, w_dlen[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? LW'(w_trial[k] - {1'b0, w_dlen[k]}) : LW'(w_trial[k]);
                r_dlen[k] <= w_dlen[k];
                r_quo[k]  <= {w_quo[k][QDW-2:0], w_ge};
                r_dneg[k] <= w_dneg[k];
            end
        end
    end

    // square root stages: one root bit a stage, remainder kept as d - root^2
    logic [QDW-1:0] r_srem [RW];
    logic [RW-1:0]  r_root [RW];
    logic           r_sneg [RW];

    logic [QDW-1:0] w_srem [RW];
    logic [RW-1:0]  w_root [RW];
    logic           w_sneg [RW];

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int B = RW - 1 - j;
        logic [SW-1:0] w_t;
        logic          w_ok;
        if (j == 0) begin : g_first
            assign w_srem[j] = r_quo[QDW-1];
            assign w_root[j] = '0;
            assign w_sneg[j] = r_dneg[QDW-1];
        end else begin : g_next
            assign w_srem[j] = r_srem[j-1];
            assign w_root[j] = r_root[j-1];
            assign w_sneg[j] = r_sneg[j-1];
        end
        assign w_t  = (SW'(w_root[j]) << (B + 1)) + (SW'(1) << (2 * B));
        assign w_ok = (SW'(w_srem[j]) >= w_t);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[j] <= w_ok ? QDW'(SW'(w_srem[j]) - w_t) : w_srem[j];
                r_root[j] <= w_ok ? (w_root[j] | (RW'(1) << B)) : w_root[j];
                r_sneg[j] <= w_sneg[j];
            end
        end
    end

    // halving the root with round half up gives the rounded magnitude
    logic [RW-1:0] w_mag;
    logic signed [tfn_pkg::OW-1:0] r_q;

    assign w_mag = (r_root[RW-1] + RW'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_sneg[RW-1] ? -tfn_pkg::OW'(w_mag) : tfn_pkg::OW'(w_mag);
        end
    end

    assign o_q = r_q;

endmodule
